@@ src/c8_pkg.sv @@
`default_nettype none
package c8_pkg;
  // Item operations.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_PIXEL = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [11:0] PC_RESET = 12'h200;
  localparam int unsigned SCREEN_PIXELS = 2048;
  localparam int unsigned PIXEL_BITS = 11;
  localparam int unsigned MEM_BITS = 12;

  // ALU function codes for the shared unit.
  localparam logic [2:0] ALU_MOV = 3'd0;
  localparam logic [2:0] ALU_OR  = 3'd1;
  localparam logic [2:0] ALU_AND = 3'd2;
  localparam logic [2:0] ALU_XOR = 3'd3;
  localparam logic [2:0] ALU_ADD = 3'd4;
  localparam logic [2:0] ALU_SUB = 3'd5;
  localparam logic [2:0] ALU_SHR = 3'd6;

  typedef struct packed {
    logic [7:0] result;
    logic       flag;
  } alu_out_t;
endpackage
`default_nettype wire

@@ src/c8_ram.sv @@
`default_nettype none
module c8_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/c8_alu.sv @@
`default_nettype none
module c8_alu (
  input  wire [2:0]         func,
  input  wire [7:0]         a,
  input  wire [7:0]         b,
  output c8_pkg::alu_out_t  y
);
  logic [8:0] sum;
  // Shared 8-bit arithmetic unit for ALU ops and immediate adds.
  always_comb begin
    sum = 9'd0;
    y.result = 8'd0;
    y.flag = 1'b0;
    case (func)
      c8_pkg::ALU_MOV: y.result = b;
      c8_pkg::ALU_OR:  y.result = a | b;
      c8_pkg::ALU_AND: y.result = a & b;
      c8_pkg::ALU_XOR: y.result = a ^ b;
      c8_pkg::ALU_ADD: begin
        sum = {1'b0, a} + {1'b0, b};
        y.result = sum[7:0];
        y.flag = sum[8];
      end
      c8_pkg::ALU_SUB: begin
        sum = {1'b0, a} - {1'b0, b};
        y.result = sum[7:0];
        y.flag = ~sum[8];
      end
      c8_pkg::ALU_SHR: begin
        y.result = {1'b0, a[7:1]};
        y.flag = a[0];
      end
      default: y.result = 8'd0;
    endcase
  end
endmodule
`default_nettype wire

@@ src/chip8_instruction_core.sv @@
// CHIP-8 instruction core.
// Input channel (in_valid/in_stall): operation, address, write_data, keys_pressed,
// random_byte. Output channel (out_valid/out_stall): status, read_data,
// program_counter, collision. One result item per input item.
// The core handles one item at a time: in_stall is high while an item is in
// work or while its result waits, and falls at the edge that takes the result.
// A memory write is done as the item is taken; a memory or pixel read passes
// through S_RD or S_PRD; most instructions take two byte fetches through the
// single memory read port, then one pass through the shared ALU.
// CLS sweeps the 2048-pixel screen one pixel a cycle.
// DRW reads each of its n rows in S_DROW and S_DRD, visits each sprite bit in
// S_DPIX, and adds S_DWR for each set bit, the read-modify-write of the
// screen memory.
// After reset, a clearing pass walks all of main memory and the
// screen alongside before the first item is accepted; registers, stack and
// pc reset at once. A result is held unchanged while out_stall is high.
`default_nettype none
module chip8_instruction_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  operation,
  input  wire  [11:0] address,
  input  wire  [7:0]  write_data,
  input  wire  [15:0] keys_pressed,
  input  wire  [7:0]  random_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        status,
  output logic [7:0]  read_data,
  output logic [11:0] program_counter,
  output logic        collision
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_F0    = 4'd3;
  localparam logic [3:0] S_F1    = 4'd4;
  localparam logic [3:0] S_F2    = 4'd5;
  localparam logic [3:0] S_EXEC  = 4'd6;
  localparam logic [3:0] S_CLS   = 4'd7;
  localparam logic [3:0] S_DROW  = 4'd8;
  localparam logic [3:0] S_DRD   = 4'd9;
  localparam logic [3:0] S_DPIX  = 4'd10;
  localparam logic [3:0] S_DWR   = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;
  localparam logic [3:0] S_PRD   = 4'd13;

  logic [3:0]  state;
  logic [12:0] sweep;
  logic [11:0] addr;
  logic [15:0] keys;
  logic [7:0]  rnd;
  logic [15:0] opcode;
  logic [11:0] pc;
  logic [15:0] index_reg;
  logic [3:0]  sp;
  logic [7:0]  delay;
  logic [7:0]  vreg [16];
  logic [11:0] stack [16];
  logic [3:0]  row;
  logic [2:0]  col;
  logic [7:0]  bits;
  logic [10:0] pix;
  logic [5:0]  dx;
  logic [4:0]  dy;

  // Main memory port signals.
  logic        m_we;
  logic [11:0] m_waddr, m_raddr;
  logic [7:0]  m_wdata, m_rdata;
  // Screen memory port signals.
  logic        s_we;
  logic [10:0] s_waddr, s_raddr;
  logic [0:0]  s_wdata, s_rdata;

  c8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata));
  c8_ram #(.WIDTH(1), .DEPTH(2048)) u_scr (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));

  logic [3:0] x, y;
  logic [7:0] vx, vy, kk;
  assign x  = opcode[11:8];
  assign y  = opcode[7:4];
  assign kk = opcode[7:0];
  assign vx = vreg[x];
  assign vy = vreg[y];

  // Shared ALU operand selection.
  logic [2:0] alu_func;
  logic [7:0] alu_b;
  c8_pkg::alu_out_t alu_y;
  always_comb begin
    alu_func = c8_pkg::ALU_MOV;
    alu_b = vy;
    case (opcode[15:12])
      4'h6: alu_b = kk;
      4'h7: begin alu_func = c8_pkg::ALU_ADD; alu_b = kk; end
      4'hC: alu_b = rnd & kk;
      4'h8: alu_func = opcode[2:0];
      default: alu_b = vy;
    endcase
  end
  c8_alu u_alu (.func(alu_func), .a(vx), .b(alu_b), .y(alu_y));

  // Pixel address of current sprite bit, wrapping at the edges. The origin
  // is latched at the start of the draw so VF updates cannot move it.
  logic [5:0] sx;
  logic [4:0] sy;
  assign sx = dx + {3'd0, col};
  assign sy = dy + {1'b0, row};

  logic key_hit;
  assign key_hit = keys[vx[3:0]];

  // Memory port control.
  always_comb begin
    m_we = 1'b0;
    m_waddr = addr;
    m_wdata = write_data;
    m_raddr = addr;
    s_we = 1'b0;
    s_waddr = pix;
    s_wdata = ~s_rdata;
    s_raddr = pix;
    case (state)
      S_CLEAR: begin
        m_we = 1'b1;
        m_waddr = sweep[11:0];
        m_wdata = 8'd0;
        s_we = 1'b1;
        s_waddr = sweep[10:0];
        s_wdata = 1'b0;
      end
      S_IDLE: begin
        m_we = in_valid && (operation == c8_pkg::OP_WRITE);
        m_waddr = address;
        m_raddr = address;
        s_raddr = address[10:0];
      end
      S_RD: m_raddr = addr;
      S_PRD: s_raddr = addr[10:0];
      S_F0: m_raddr = pc;
      S_F1: m_raddr = pc + 12'd1;
      S_CLS: begin
        s_we = 1'b1;
        s_waddr = sweep[10:0];
        s_wdata = 1'b0;
      end
      S_DROW: m_raddr = index_reg[11:0] + {8'd0, row};
      S_DWR: s_we = 1'b1;
      default: m_raddr = addr;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep <= 13'd0;
      pc <= c8_pkg::PC_RESET;
      index_reg <= 16'd0;
      sp <= 4'd0;
      delay <= 8'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        vreg[i] <= 8'd0;
        stack[i] <= 12'd0;
      end
    end else begin
      case (state)
        S_CLEAR: begin
          sweep <= sweep + 13'd1;
          if (sweep == 13'd4095) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            addr <= address;
            keys <= keys_pressed;
            rnd <= random_byte;
            status <= 1'b0;
            read_data <= 8'd0;
            collision <= 1'b0;
            case (operation)
              c8_pkg::OP_WRITE: state <= S_OUT;
              c8_pkg::OP_READ:  state <= S_RD;
              c8_pkg::OP_PIXEL: state <= S_PRD;
              default:          state <= S_F0;
            endcase
          end
        end
        S_RD: begin
          read_data <= m_rdata;
          state <= S_OUT;
        end
        S_PRD: begin
          read_data <= {7'd0, s_rdata};
          state <= S_OUT;
        end
        S_F0: state <= S_F1;
        S_F1: begin
          opcode[15:8] <= m_rdata;
          state <= S_F2;
        end
        S_F2: begin
          opcode[7:0] <= m_rdata;
          state <= S_EXEC;
        end
        S_EXEC: begin
          pc <= pc + 12'd2;
          state <= S_OUT;
          case (opcode[15:12])
            4'h0: begin
              if (kk == 8'hE0) begin
                sweep <= 13'd0;
                state <= S_CLS;
              end else if (kk == 8'hEE) begin
                sp <= sp - 4'd1;
                pc <= stack[sp - 4'd1] + 12'd2;
              end else begin
                status <= 1'b1;
              end
            end
            4'h1: pc <= opcode[11:0];
            4'h2: begin
              stack[sp] <= pc;
              sp <= sp + 4'd1;
              pc <= opcode[11:0];
            end
            4'h3: if (vx == kk) pc <= pc + 12'd4;
            4'h4: if (vx != kk) pc <= pc + 12'd4;
            4'h6, 4'h7, 4'hC: vreg[x] <= alu_y.result;
            4'h8: begin
              if (opcode[3]) begin
                status <= 1'b1;
              end else if (opcode[2:0] == 3'd7) begin
                status <= 1'b1;
              end else if (opcode[2:0] >= c8_pkg::ALU_ADD) begin
                // The flag wins when the destination is VF.
                vreg[15] <= {7'd0, alu_y.flag};
                if (x != 4'hF) vreg[x] <= alu_y.result;
              end else begin
                vreg[x] <= alu_y.result;
              end
            end
            4'hA: index_reg <= {4'd0, opcode[11:0]};
            4'hD: begin
              vreg[15] <= 8'd0;
              row <= 4'd0;
              dx <= vx[5:0];
              dy <= vy[4:0];
              state <= (opcode[3:0] == 4'd0) ? S_OUT : S_DROW;
            end
            4'hE: begin
              if (kk == 8'h9E) begin
                if (key_hit) pc <= pc + 12'd4;
              end else if (kk == 8'hA1) begin
                if (!key_hit) pc <= pc + 12'd4;
              end else begin
                status <= 1'b1;
              end
            end
            4'hF: begin
              if (kk == 8'h07) vreg[x] <= delay;
              else if (kk == 8'h15) delay <= vx;
              else if (kk == 8'h1E) index_reg <= index_reg + {8'd0, vx};
              else status <= 1'b1;
            end
            default: status <= 1'b1;
          endcase
        end
        S_CLS: begin
          sweep <= sweep + 13'd1;
          if (sweep[10:0] == 11'd2047) state <= S_OUT;
        end
        S_DROW: state <= S_DRD;
        S_DRD: begin
          bits <= m_rdata;
          col <= 3'd0;
          pix <= {sy, dx};
          state <= S_DPIX;
        end
        S_DPIX: begin
          // Skip clear sprite bits; set bits need a screen read then write.
          if (bits[7]) begin
            state <= S_DWR;
          end else if (col == 3'd7) begin
            row <= row + 4'd1;
            state <= (row + 4'd1 == opcode[3:0]) ? S_OUT : S_DROW;
          end else begin
            bits <= {bits[6:0], 1'b0};
            col <= col + 3'd1;
            pix <= {sy, sx + 6'd1};
          end
        end
        S_DWR: begin
          if (s_rdata[0]) begin
            collision <= 1'b1;
            vreg[15] <= 8'd1;
          end
          bits <= {bits[6:0], 1'b0};
          if (col == 3'd7) begin
            row <= row + 4'd1;
            state <= (row + 4'd1 == opcode[3:0]) ? S_OUT : S_DROW;
          end else begin
            col <= col + 3'd1;
            pix <= {sy, sx + 6'd1};
            state <= S_DPIX;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign program_counter = pc;

  // Checks on the sequencer.
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("result shown outside output state");
  a_idle_no_result: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !out_valid) else $error("result pending while idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(program_counter))
    else $error("stalled result changed");
endmodule
`default_nettype wire
